@@ src/hdc_pkg.sv @@
// hdc_pkg: shared types and constants of the heading deviation correction block.
// No dependencies.
`default_nettype none
package hdc_pkg;
   localparam int unsigned FULL_CIRCLE = 36000;
   localparam int unsigned HALF_CIRCLE = 18000;
   localparam int unsigned N_POINTS = 4;
   localparam int unsigned TRUE_STEP = 9000;

   // register indexes
   localparam logic [2:0] REG_NORTH = 3'd0;
   localparam logic [2:0] REG_EAST = 3'd1;
   localparam logic [2:0] REG_SOUTH = 3'd2;
   localparam logic [2:0] REG_WEST = 3'd3;

   typedef struct packed {
      logic [15:0] ind;
      logic signed [15:0] corr;
   } point_type;

   // sideband that rides along the divider
   typedef struct packed {
      logic [15:0] h;
      logic signed [15:0] c0;
      logic neg;
      logic zero;
   } tag_type;
endpackage
`default_nettype wire

@@ src/hdc_points.sv @@
// hdc_points: calibration registers, correction per point and stable sort.
// Depends on hdc_pkg.
`default_nettype none
module hdc_points (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data,
   output hdc_pkg::point_type [3:0] pts
);
   logic [15:0] regs_ff [4];
   hdc_pkg::point_type [3:0] pts_ff, pts_in;
   hdc_pkg::point_type [3:0] raw_pts;
   logic [1:0] rank [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[0] <= 16'(0);
         regs_ff[1] <= 16'(hdc_pkg::TRUE_STEP);
         regs_ff[2] <= 16'(2 * hdc_pkg::TRUE_STEP);
         regs_ff[3] <= 16'(3 * hdc_pkg::TRUE_STEP);
      end else if (csr_we) begin
         unique case (csr_index)
            hdc_pkg::REG_NORTH: regs_ff[0] <= csr_data;
            hdc_pkg::REG_EAST: regs_ff[1] <= csr_data;
            hdc_pkg::REG_SOUTH: regs_ff[2] <= csr_data;
            hdc_pkg::REG_WEST: regs_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [15:0] ind;
      logic signed [17:0] cc;
      logic [2:0] cnt;
      for (int i = 0; i < 4; i++) begin
         ind = (regs_ff[i] >= 16'(hdc_pkg::FULL_CIRCLE)) ?
               regs_ff[i] - 16'(hdc_pkg::FULL_CIRCLE) : regs_ff[i];
         cc = 18'sd9000 * 18'(i) - $signed({2'b00, ind});
         if (cc > 18'sd18000) cc = cc - 18'sd36000;
         if (cc < -18'sd18000) cc = cc + 18'sd36000;
         raw_pts[i].ind = ind;
         raw_pts[i].corr = 16'(cc);
      end
      // stable rank: smaller values, and equal values from lower registers
      for (int i = 0; i < 4; i++) begin
         cnt = 3'd0;
         for (int j = 0; j < 4; j++) begin
            if (raw_pts[j].ind < raw_pts[i].ind ||
                (j < i && raw_pts[j].ind == raw_pts[i].ind))
               cnt = cnt + 3'd1;
         end
         rank[i] = cnt[1:0];
      end
      pts_in = raw_pts;
      for (int i = 0; i < 4; i++) pts_in[rank[i]] = raw_pts[i];
   end

   always_ff @(posedge clock) begin
      pts_ff <= pts_in;
   end

   assign pts = pts_ff;
endmodule
`default_nettype wire

@@ src/hdc_divider.sv @@
// hdc_divider: four-stage restoring divider, four quotient bits per stage.
// Quotient is known to fit 16 bits. Depends on hdc_pkg.
`default_nettype none
module hdc_divider (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   input wire logic [30:0] in_num,
   input wire logic [15:0] in_den,
   input wire hdc_pkg::tag_type in_tag,
   output logic out_valid,
   output logic [15:0] out_quot,
   output hdc_pkg::tag_type out_tag
);
   logic v_ff [4];
   logic [15:0] rem_ff [4], low_ff [4], quot_ff [4], den_ff [4];
   hdc_pkg::tag_type tag_ff [4];
   logic [15:0] rem_in [4], quot_in [4];

   always_comb begin
      logic [16:0] r;
      logic [15:0] q, low, d;
      for (int s = 0; s < 4; s++) begin
         if (s == 0) begin
            r = {2'b00, in_num[30:16]};
            q = 16'd0;
            low = in_num[15:0];
            d = in_den;
         end else begin
            r = {1'b0, rem_ff[s-1]};
            q = quot_ff[s-1];
            low = low_ff[s-1];
            d = den_ff[s-1];
         end
         for (int k = 0; k < 4; k++) begin
            r = {r[15:0], low[15 - 4*s - k]};
            if (r >= {1'b0, d}) begin
               r = r - {1'b0, d};
               q = {q[14:0], 1'b1};
            end else begin
               q = {q[14:0], 1'b0};
            end
         end
         rem_in[s] = r[15:0];
         quot_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < 4; s++) begin
         rem_ff[s] <= rem_in[s];
         quot_ff[s] <= quot_in[s];
         if (s == 0) begin
            low_ff[s] <= in_num[15:0];
            den_ff[s] <= in_den;
            tag_ff[s] <= in_tag;
         end else begin
            low_ff[s] <= low_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            tag_ff[s] <= tag_ff[s-1];
         end
      end
      if (reset) begin
         for (int s = 0; s < 4; s++) v_ff[s] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < 4; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   assign out_valid = v_ff[3];
   assign out_quot = quot_ff[3];
   assign out_tag = tag_ff[3];
endmodule
`default_nettype wire

@@ src/heading_deviation_correct_top.sv @@
// heading_deviation_correct_top: compass deviation correction pipeline.
// Depends on hdc_pkg, hdc_points, hdc_divider.
//
//   channel  ports                         direction  handshake
//   req      start busy req_raw_heading    in         start & !busy
//   rsp      rsp_valid rsp_true_heading    out        one-cycle strobe
//   csr      csr_we csr_index csr_data     in         write on csr_we
//
// One item enters every cycle; busy is always low. The pipeline stages are,
// in order: normalize, segment select, multiply, four divider stages, final wrap.
// Synchronous reset clears valid bits and loads the register reset values; a
// write lands in the calibration register, then in the registered point table,
// and then takes effect. The receiver cannot stall, so nothing is held back.
`default_nettype none
module heading_deviation_correct_top (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic signed [17:0] req_raw_heading,
   output logic rsp_valid,
   output logic [15:0] rsp_true_heading,
   input wire logic csr_we,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data
);
   hdc_pkg::point_type [3:0] pts;
   logic accept;

   logic v1_ff, v2_ff, v3_ff, out_v_ff;
   logic [15:0] h1_ff, h1_in;
   logic [15:0] d2_ff, span2_ff, h2_ff;
   logic signed [16:0] dc2_ff;
   logic signed [15:0] c02_ff;
   logic [15:0] d2_in, span2_in;
   logic signed [16:0] dc2_in;
   logic signed [15:0] c02_in;
   logic [16:0] dc2_mag;
   logic [30:0] num3_ff;
   logic [15:0] den3_ff;
   hdc_pkg::tag_type tag3_ff;
   logic div_v;
   logic [15:0] div_q;
   hdc_pkg::tag_type div_tag;
   logic [15:0] out_ff, out_in;

   assign busy = 1'b0;
   assign accept = start & ~busy;

   hdc_points u_points (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_data(csr_data), .pts(pts)
   );

   // full reduction of any 18-bit pattern: offset by four circles, then pick
   always_comb begin
      logic signed [19:0] v;
      v = 20'(req_raw_heading) + 20'sd144000;
      h1_in = 16'(v);
      for (int m = 1; m < 8; m++) begin
         if (v >= 20'sd36000 * 20'(m)) h1_in = 16'(v - 20'sd36000 * 20'(m));
      end
   end

   always_comb begin
      logic found;
      found = 1'b0;
      d2_in = 16'(h1_ff + 16'(hdc_pkg::FULL_CIRCLE) - pts[3].ind);
      if (h1_ff >= pts[3].ind) d2_in = h1_ff - pts[3].ind;
      span2_in = 16'(pts[0].ind + 16'(hdc_pkg::FULL_CIRCLE) - pts[3].ind);
      c02_in = pts[3].corr;
      dc2_in = 17'(pts[0].corr) - 17'(pts[3].corr);
      for (int i = 0; i < 3; i++) begin
         if (!found && h1_ff >= pts[i].ind && h1_ff < pts[i+1].ind) begin
            found = 1'b1;
            d2_in = h1_ff - pts[i].ind;
            span2_in = pts[i+1].ind - pts[i].ind;
            c02_in = pts[i].corr;
            dc2_in = 17'(pts[i+1].corr) - 17'(pts[i].corr);
         end
      end
   end

   assign dc2_mag = dc2_ff[16] ? 17'(-dc2_ff) : 17'(dc2_ff);

   // quotient can reach 35999, so it needs a sign bit of its own
   always_comb begin
      logic signed [16:0] q;
      logic signed [17:0] s;
      q = div_tag.neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      s = 18'({2'b00, div_tag.h}) + 18'(div_tag.c0) + 18'(q);
      if (s < 0) s = s + 18'sd36000;
      else if (s >= 18'sd36000) s = s - 18'sd36000;
      out_in = div_tag.zero ? div_tag.h : 16'(s);
   end

   always_ff @(posedge clock) begin
      h1_ff <= h1_in;
      d2_ff <= d2_in;
      span2_ff <= span2_in;
      dc2_ff <= dc2_in;
      c02_ff <= c02_in;
      h2_ff <= h1_ff;
      num3_ff <= 31'({16'd0, d2_ff} * {15'd0, dc2_mag});
      den3_ff <= span2_ff;
      tag3_ff.h <= h2_ff;
      tag3_ff.c0 <= c02_ff;
      tag3_ff.neg <= dc2_ff[16];
      tag3_ff.zero <= (span2_ff == 16'd0);
      out_ff <= out_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         out_v_ff <= div_v;
      end
   end

   hdc_divider u_div (
      .clock(clock), .reset(reset), .in_valid(v3_ff), .in_num(num3_ff),
      .in_den(den3_ff), .in_tag(tag3_ff), .out_valid(div_v), .out_quot(div_q),
      .out_tag(div_tag)
   );

   assign rsp_valid = out_v_ff;
   assign rsp_true_heading = out_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##8 rsp_valid) else $error("item lost in pipeline");
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 8)) else $error("result without item");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_true_heading < 16'd36000) else $error("heading out of range");
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("strobe after reset");
endmodule
`default_nettype wire
